/* rtl/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// btpc_pkg: shared types and constants for the pair cost block
// Item structs for both channels, register index codes and fixed weights.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

  typedef struct packed {
    logic [11:0] det_x;
    logic [11:0] det_y;
    logic [11:0] det_w;
    logic [11:0] det_h;
    logic [11:0] trk_x;
    logic [11:0] trk_y;
    logic [11:0] trk_w;
    logic [11:0] trk_h;
    logic [7:0]  trk_misses;
  } pair_in_t;

  typedef struct packed {
    logic [23:0] pair_cost;
    logic        gated;
    logic [16:0] overlap;
    logic        near_edge;
  } pair_out_t;

  // register index codes
  localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_EDGE_FRACTION  = 3'd2;
  localparam logic [2:0] CFG_DISTANCE_SCALE = 3'd3;
  localparam logic [2:0] CFG_MISS_LIMIT     = 3'd4;
  localparam logic [2:0] CFG_OVERLAP_WEIGHT = 3'd5;
  localparam logic [2:0] CFG_AREA_WEIGHT    = 3'd6;
  localparam logic [2:0] CFG_CENTRE_WEIGHT  = 3'd7;

  localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd1920;
  localparam logic [11:0] RST_IMAGE_HEIGHT   = 12'd1080;
  localparam logic [15:0] RST_EDGE_FRACTION  = 16'd3277;
  localparam logic [15:0] RST_DISTANCE_SCALE = 16'd256;
  localparam logic [7:0]  RST_MISS_LIMIT     = 8'd10;
  localparam logic [15:0] RST_WEIGHT         = 16'd4096;

  localparam logic [15:0] RATIO_WEIGHT_Q12 = 16'd4096;
  localparam logic [15:0] MISS_WEIGHT_Q12  = 16'd4096;
  localparam logic [15:0] EDGE_WEIGHT_Q12  = 16'd4096;
  localparam logic [23:0] GATE_COST_Q16    = 24'd655360;
  localparam logic [16:0] ONE_Q16          = 17'd65536;
  localparam logic [23:0] COST_MAX         = 24'hFFFFFF;

endpackage

`default_nettype wire

/* rtl/box_track_pair_cost.sv */
// Throughput: one item per cycle while no finished result is held by rsp_stall;
//   the stage chain holds the 48-step centre-distance quotient, 24-step square
//   root and 17-step divide.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all stage valid bits and loads register reset values.
// ----------------------------------------------------------------------------
// box_track_pair_cost: detection/track association cost
// IoU, area, ratio, centre distance, miss and edge terms, weighted and gated.
// ----------------------------------------------------------------------------
`default_nettype none

module box_track_pair_cost (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_stall,
  input  btpc_pkg::pair_in_t   req_data,
  output logic                 rsp_valid,
  input  wire                  rsp_stall,
  output btpc_pkg::pair_out_t  rsp_data,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [15:0]          cfg_data
);
  import btpc_pkg::*;

  localparam int DIV_FIRST = 4;
  localparam int OV_LAST   = DIV_FIRST + 16;
  localparam int MS_LAST   = DIV_FIRST + 23;
  localparam int QD_LAST   = DIV_FIRST + 47;
  localparam int SQ_FIRST  = QD_LAST + 1;
  localparam int SQ_LAST   = SQ_FIRST + 23;
  localparam int TD_FIRST  = SQ_LAST + 1;
  localparam int TD_LAST   = TD_FIRST + 16;
  localparam int MUL_STG   = TD_LAST + 1;
  localparam int SUM_STG   = MUL_STG + 1;
  localparam int DEPTH     = SUM_STG + 1;

  typedef struct packed {
    logic [23:0]        s1;
    logic [23:0]        s2;
    logic [23:0]        r1;
    logic [23:0]        r2;
    logic [11:0]        iw;
    logic [11:0]        ih;
    logic signed [13:0] cx;
    logic signed [13:0] cy;
    logic [11:0]        tx;
    logic [11:0]        ty;
    logic [12:0]        txe;
    logic [12:0]        tye;
    logic [7:0]         misses;
    logic [23:0]        inter;
    logic [25:0]        cx2;
    logic [25:0]        cy2;
    logic [23:0]        mins;
    logic [23:0]        sdiff;
    logic [23:0]        rmax;
    logic [23:0]        rmin;
    logic               zero;
    logic               near;
    logic [24:0]        uni;
    logic [26:0]        d2;
    logic [23:0]        rdiff;
    logic               gate0;
    logic [55:0]        dsm;
    logic               gated;
    logic               uni_zero;
    logic [24:0]        ov_rem;
    logic [16:0]        ov_lo;
    logic [23:0]        ar_rem;
    logic [16:0]        ar_lo;
    logic [23:0]        ra_rem;
    logic [16:0]        ra_lo;
    logic [7:0]         ms_rem;
    logic [23:0]        ms_lo;
    logic [23:0]        qd_rem;
    logic [47:0]        qd_lo;
    logic [25:0]        sq_r;
    logic [23:0]        sq_y;
    logic [47:0]        sq_v;
    logic [15:0]        td_rem;
    logic [16:0]        td_lo;
    logic [16:0]        ovl;
    logic [32:0]        m_iou;
    logic [32:0]        m_area;
    logic [32:0]        m_ratio;
    logic [32:0]        m_dist;
    logic [39:0]        m_miss;
    logic [31:0]        m_edge;
    logic [23:0]        cost;
  } pipe_t;

  // configuration registers
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [15:0] edge_fraction;
  logic [15:0] distance_scale;
  logic [7:0]  miss_limit;
  logic [15:0] overlap_weight;
  logic [15:0] area_weight;
  logic [15:0] centre_weight;

  // derived from configuration; edge_w, edge_h and dist_sq registered, miss_lim combinational
  logic [27:0] edge_w;
  logic [27:0] edge_h;
  logic [31:0] dist_sq;
  logic [7:0]  miss_lim;

  pipe_t pl  [DEPTH];
  logic  vld [DEPTH];
  logic  adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      edge_fraction  <= RST_EDGE_FRACTION;
      distance_scale <= RST_DISTANCE_SCALE;
      miss_limit     <= RST_MISS_LIMIT;
      overlap_weight <= RST_WEIGHT;
      area_weight    <= RST_WEIGHT;
      centre_weight  <= RST_WEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[11:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[11:0];
        CFG_EDGE_FRACTION:  edge_fraction  <= cfg_data;
        CFG_DISTANCE_SCALE: distance_scale <= cfg_data;
        CFG_MISS_LIMIT:     miss_limit     <= cfg_data[7:0];
        CFG_OVERLAP_WEIGHT: overlap_weight <= cfg_data;
        CFG_AREA_WEIGHT:    area_weight    <= cfg_data;
        CFG_CENTRE_WEIGHT:  centre_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    edge_w  <= 28'(edge_fraction * image_width);
    edge_h  <= 28'(edge_fraction * image_height);
    dist_sq <= 32'(distance_scale * distance_scale);
  end

  assign miss_lim = (miss_limit == 8'd0) ? 8'd1 : miss_limit;

  // whole pipeline moves unless a finished result is held
  assign adv       = !(vld[DEPTH-1] && rsp_stall);
  assign req_stall = !adv;

  for (genvar k = 0; k < DEPTH; k++) begin : g_stg
    pipe_t st;

    if (k == 0) begin : g_a
      logic [12:0] ix0, ix1, iy0, iy1, dxe, dye, txe, tye;
      always_comb begin
        st     = '0;
        dxe    = {1'b0, req_data.det_x} + {1'b0, req_data.det_w};
        dye    = {1'b0, req_data.det_y} + {1'b0, req_data.det_h};
        txe    = {1'b0, req_data.trk_x} + {1'b0, req_data.trk_w};
        tye    = {1'b0, req_data.trk_y} + {1'b0, req_data.trk_h};
        ix0    = {1'b0, (req_data.det_x > req_data.trk_x) ? req_data.det_x : req_data.trk_x};
        iy0    = {1'b0, (req_data.det_y > req_data.trk_y) ? req_data.det_y : req_data.trk_y};
        ix1    = (dxe < txe) ? dxe : txe;
        iy1    = (dye < tye) ? dye : tye;
        st.s1  = 24'(req_data.det_w * req_data.det_h);
        st.s2  = 24'(req_data.trk_w * req_data.trk_h);
        st.r1  = 24'(req_data.det_w * req_data.trk_h);
        st.r2  = 24'(req_data.trk_w * req_data.det_h);
        st.iw  = (ix1 > ix0) ? 12'(ix1 - ix0) : 12'd0;
        st.ih  = (iy1 > iy0) ? 12'(iy1 - iy0) : 12'd0;
        // centres use x + w/2
        st.cx  = $signed(14'({2'b0, req_data.det_x} + {3'b0, req_data.det_w[11:1]}))
               - $signed(14'({2'b0, req_data.trk_x} + {3'b0, req_data.trk_w[11:1]}));
        st.cy  = $signed(14'({2'b0, req_data.det_y} + {3'b0, req_data.det_h[11:1]}))
               - $signed(14'({2'b0, req_data.trk_y} + {3'b0, req_data.trk_h[11:1]}));
        st.tx  = req_data.trk_x;
        st.ty  = req_data.trk_y;
        st.txe = txe;
        st.tye = tye;
        st.misses = req_data.trk_misses;
      end
    end else if (k == 1) begin : g_b
      logic signed [27:0] sqx, sqy;
      logic signed [13:0] gx, gy;
      always_comb begin
        st       = pl[k-1];
        sqx      = pl[k-1].cx * pl[k-1].cx;
        sqy      = pl[k-1].cy * pl[k-1].cy;
        st.inter = 24'(pl[k-1].iw * pl[k-1].ih);
        st.cx2   = sqx[25:0];
        st.cy2   = sqy[25:0];
        st.mins  = (pl[k-1].s1 < pl[k-1].s2) ? pl[k-1].s1 : pl[k-1].s2;
        st.sdiff = (pl[k-1].s1 > pl[k-1].s2) ? pl[k-1].s1 - pl[k-1].s2
                                             : pl[k-1].s2 - pl[k-1].s1;
        st.rmax  = (pl[k-1].r1 > pl[k-1].r2) ? pl[k-1].r1 : pl[k-1].r2;
        st.rmin  = (pl[k-1].r1 < pl[k-1].r2) ? pl[k-1].r1 : pl[k-1].r2;
        st.zero  = (pl[k-1].s1 == 24'd0) || (pl[k-1].s2 == 24'd0);
        // gap to far border; negative means past the image
        gx       = $signed({2'b0, image_width})  - $signed({1'b0, pl[k-1].txe});
        gy       = $signed({2'b0, image_height}) - $signed({1'b0, pl[k-1].tye});
        st.near  = ({pl[k-1].tx, 16'h0} < edge_w) || ({pl[k-1].ty, 16'h0} < edge_h)
                || gx[13] || ({gx[11:0], 16'h0} < edge_w)
                || gy[13] || ({gy[11:0], 16'h0} < edge_h);
      end
    end else if (k == 2) begin : g_c
      always_comb begin
        st       = pl[k-1];
        st.uni   = 25'({1'b0, pl[k-1].s1} + {1'b0, pl[k-1].s2} - {1'b0, pl[k-1].inter});
        st.d2    = 27'({1'b0, pl[k-1].cx2} + {1'b0, pl[k-1].cy2});
        st.rdiff = pl[k-1].rmax - pl[k-1].rmin;
        st.gate0 = pl[k-1].zero || (pl[k-1].sdiff > pl[k-1].mins)
                || ({1'b0, pl[k-1].rmax} > {pl[k-1].rmin, 1'b0});
        st.dsm   = 56'(dist_sq * pl[k-1].mins);
      end
    end else if (k == 3) begin : g_d
      always_comb begin
        st          = pl[k-1];
        st.gated    = pl[k-1].gate0 || ({13'h0, pl[k-1].d2, 16'h0} > pl[k-1].dsm);
        st.uni_zero = (pl[k-1].uni == 25'd0);
        st.ov_rem   = {2'b0, pl[k-1].inter[23:1]};
        st.ov_lo    = {pl[k-1].inter[0], 16'h0};
        st.ar_rem   = {1'b0, pl[k-1].sdiff[23:1]};
        st.ar_lo    = {pl[k-1].sdiff[0], 16'h0};
        st.ra_rem   = {1'b0, pl[k-1].rdiff[23:1]};
        st.ra_lo    = {pl[k-1].rdiff[0], 16'h0};
        st.ms_rem   = 8'd0;
        st.ms_lo    = {pl[k-1].misses, 16'h0};
        st.qd_rem   = {13'h0, pl[k-1].d2[26:16]};
        st.qd_lo    = {pl[k-1].d2[15:0], 32'h0};
      end
    end else begin : g_step
      logic [25:0] ov_t;
      logic [24:0] ar_t, ra_t, qd_t;
      logic [8:0]  ms_t;
      logic [27:0] sq_t, sq_try;
      logic [16:0] td_t;
      logic        ge;
      logic [16:0] tiou, tdist;
      logic [41:0] sum;
      logic [29:0] raw;
      always_comb begin
        st     = pl[k-1];
        ov_t   = '0;
        ar_t   = '0;
        ra_t   = '0;
        qd_t   = '0;
        ms_t   = '0;
        sq_t   = '0;
        sq_try = '0;
        td_t   = '0;
        ge     = 1'b0;
        tiou   = '0;
        tdist  = '0;
        sum    = '0;
        raw    = '0;
        // restoring dividers, one quotient bit per stage
        if (k <= OV_LAST) begin
          ov_t = {st.ov_rem, st.ov_lo[16]};
          ge   = (ov_t >= {1'b0, st.uni});
          st.ov_rem = ge ? 25'(ov_t - {1'b0, st.uni}) : ov_t[24:0];
          st.ov_lo  = {st.ov_lo[15:0], ge};
          ar_t = {st.ar_rem, st.ar_lo[16]};
          ge   = (ar_t >= {1'b0, st.mins});
          st.ar_rem = ge ? 24'(ar_t - {1'b0, st.mins}) : ar_t[23:0];
          st.ar_lo  = {st.ar_lo[15:0], ge};
          ra_t = {st.ra_rem, st.ra_lo[16]};
          ge   = (ra_t >= {1'b0, st.rmin});
          st.ra_rem = ge ? 24'(ra_t - {1'b0, st.rmin}) : ra_t[23:0];
          st.ra_lo  = {st.ra_lo[15:0], ge};
        end
        if (k <= MS_LAST) begin
          ms_t = {st.ms_rem, st.ms_lo[23]};
          ge   = (ms_t >= {1'b0, miss_lim});
          st.ms_rem = ge ? 8'(ms_t - {1'b0, miss_lim}) : ms_t[7:0];
          st.ms_lo  = {st.ms_lo[22:0], ge};
        end
        if (k <= QD_LAST) begin
          qd_t = {st.qd_rem, st.qd_lo[47]};
          ge   = (qd_t >= {1'b0, st.mins});
          st.qd_rem = ge ? 24'(qd_t - {1'b0, st.mins}) : qd_t[23:0];
          st.qd_lo  = {st.qd_lo[46:0], ge};
        end
        // integer square root, two radicand bits per stage
        if (k >= SQ_FIRST && k <= SQ_LAST) begin
          if (k == SQ_FIRST) begin
            st.sq_r = '0;
            st.sq_y = '0;
            st.sq_v = st.qd_lo;
          end
          sq_t   = {st.sq_r, st.sq_v[47:46]};
          sq_try = {2'b0, st.sq_y, 2'b01};
          ge     = (sq_t >= sq_try);
          st.sq_r = ge ? 26'(sq_t - sq_try) : sq_t[25:0];
          st.sq_y = {st.sq_y[22:0], ge};
          st.sq_v = {st.sq_v[45:0], 2'b00};
        end
        // root * 256 / distance_scale
        if (k >= TD_FIRST && k <= TD_LAST) begin
          if (k == TD_FIRST) begin
            st.td_rem = {1'b0, st.sq_y[23:9]};
            st.td_lo  = {st.sq_y[8:0], 8'h0};
          end
          td_t = {st.td_rem, st.td_lo[16]};
          ge   = (td_t >= {1'b0, distance_scale});
          st.td_rem = ge ? 16'(td_t - {1'b0, distance_scale}) : td_t[15:0];
          st.td_lo  = {st.td_lo[15:0], ge};
        end
        if (k == MUL_STG) begin
          st.ovl     = st.uni_zero ? 17'd0 : st.ov_lo;
          tiou       = ONE_Q16 - st.ovl;
          tdist      = (distance_scale == 16'd0) ? 17'd0 : st.td_lo;
          st.m_iou   = 33'(tiou * overlap_weight);
          st.m_area  = 33'(st.ar_lo * area_weight);
          st.m_ratio = 33'(st.ra_lo * RATIO_WEIGHT_Q12);
          st.m_dist  = 33'(tdist * centre_weight);
          st.m_miss  = 40'(st.ms_lo * MISS_WEIGHT_Q12);
          st.m_edge  = st.near ? {EDGE_WEIGHT_Q12, 16'h0} : 32'h0;
        end
        if (k == SUM_STG) begin
          sum = 42'(st.m_iou) + 42'(st.m_area) + 42'(st.m_ratio)
              + 42'(st.m_dist) + 42'(st.m_miss) + 42'(st.m_edge);
          raw = sum[41:12];
          if (st.gated) begin
            st.cost = GATE_COST_Q16;
          end else if (raw > 30'(COST_MAX)) begin
            st.cost = COST_MAX;
          end else begin
            st.cost = raw[23:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pl[k] <= st;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= (k == 0) ? req_valid : vld[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign rsp_valid          = vld[DEPTH-1];
  assign rsp_data.pair_cost = pl[DEPTH-1].cost;
  assign rsp_data.gated     = pl[DEPTH-1].gated;
  assign rsp_data.overlap   = pl[DEPTH-1].ovl;
  assign rsp_data.near_edge = pl[DEPTH-1].near;

`ifndef SYNTH
  a_gate_cost: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.gated |-> rsp_data.pair_cost == GATE_COST_Q16)
    else $error("gated item without gate cost");

  a_overlap_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.overlap <= ONE_Q16)
    else $error("overlap above one");

  a_ov_rem: assert property (@(posedge clk) disable iff (rst)
    vld[OV_LAST] && !pl[OV_LAST].uni_zero |-> pl[OV_LAST].ov_rem < pl[OV_LAST].uni)
    else $error("IoU divider remainder out of range");

  a_qd_rem: assert property (@(posedge clk) disable iff (rst)
    vld[QD_LAST] && !pl[QD_LAST].gated |-> pl[QD_LAST].qd_rem < pl[QD_LAST].mins)
    else $error("distance quotient remainder out of range");

  a_sq_rem: assert property (@(posedge clk) disable iff (rst)
    vld[SQ_LAST] |-> {1'b0, pl[SQ_LAST].sq_r} <= {2'b0, pl[SQ_LAST].sq_y, 1'b0})
    else $error("square root remainder above twice the root");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the detection/track pair cost block
// Directed and random box pairs under several register settings; every
// result is predicted in order and compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int LATENCY = 95;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  pair_in_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pair_out_t rsp_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;

  box_track_pair_cost dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // shadow copy of the register file
  logic [11:0] img_w_q, img_h_q;
  logic [15:0] edge_frac_q, dist_scale_q, ovl_wt_q, area_wt_q, ctr_wt_q;
  logic [7:0] miss_lim_q;

  pair_out_t cost_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  bit timed_out = 1'b0;

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic bit edge_side(longint pos, longint size);
    return pos * 65536 < longint'(edge_frac_q) * size;
  endfunction

  function automatic pair_out_t pair_cost_predict(pair_in_t p);
    pair_out_t r;
    longint dx, dy, dw, dh, tx, ty, tw, th, ix0, iy0, ix1, iy1, iw, ih, cx, cy;
    logic [63:0] s1, s2, inter, uni, ovl, mins, sdiff, r1, r2, rmax, rmin;
    logic [63:0] d2, ds2, lhs, lq, lr, t_area, t_ratio, t_dist, t_miss, t_edge;
    logic [63:0] lim, qh, rem, q, cost;
    bit near, gate;
    dx = p.det_x; dy = p.det_y; dw = p.det_w; dh = p.det_h;
    tx = p.trk_x; ty = p.trk_y; tw = p.trk_w; th = p.trk_h;
    s1 = dw * dh;
    s2 = tw * th;
    ix0 = dx > tx ? dx : tx;
    iy0 = dy > ty ? dy : ty;
    ix1 = (dx + dw) < (tx + tw) ? dx + dw : tx + tw;
    iy1 = (dy + dh) < (ty + th) ? dy + dh : ty + th;
    iw = ix1 - ix0 > 0 ? ix1 - ix0 : 0;
    ih = iy1 - iy0 > 0 ? iy1 - iy0 : 0;
    inter = iw * ih;
    uni = s1 + s2 - inter;
    ovl = uni != 0 ? (inter * 65536) / uni : 0;
    near = edge_side(tx, img_w_q) || edge_side(ty, img_h_q) ||
           edge_side(longint'(img_w_q) - (tx + tw), img_w_q) ||
           edge_side(longint'(img_h_q) - (ty + th), img_h_q);
    gate = 1'b0;
    cost = 0;
    if (s1 == 0 || s2 == 0) begin
      gate = 1'b1;
    end else begin
      mins = s1 < s2 ? s1 : s2;
      sdiff = s1 > s2 ? s1 - s2 : s2 - s1;
      r1 = dw * th;
      r2 = tw * dh;
      rmax = r1 > r2 ? r1 : r2;
      rmin = r1 < r2 ? r1 : r2;
      cx = (dx + dw / 2) - (tx + tw / 2);
      cy = (dy + dh / 2) - (ty + th / 2);
      d2 = cx * cx + cy * cy;
      ds2 = 64'(dist_scale_q) * dist_scale_q;
      lhs = d2 << 16;
      lq = lhs / mins;
      lr = lhs % mins;
      if (sdiff > mins || rmax - rmin > rmin || lq > ds2 || (lq == ds2 && lr > 0)) begin
        gate = 1'b1;
      end else begin
        t_area = (sdiff * 65536) / mins;
        t_ratio = ((rmax - rmin) * 65536) / rmin;
        t_dist = 0;
        lim = miss_lim_q == 0 ? 1 : miss_lim_q;
        if (dist_scale_q != 0) begin
          qh = d2 / mins;
          rem = d2 % mins;
          q = (qh << 32) + ((rem << 32) / mins);
          t_dist = (sqrt_floor(q) * 256) / dist_scale_q;
        end
        t_miss = (64'(p.trk_misses) * 65536) / lim;
        t_edge = near ? 65536 : 0;
        cost = (65536 - ovl) * ovl_wt_q + t_area * area_wt_q +
               t_ratio * RATIO_WEIGHT_Q12 + t_dist * ctr_wt_q +
               t_miss * MISS_WEIGHT_Q12 + t_edge * EDGE_WEIGHT_Q12;
        cost = cost >> 12;
        if (cost > COST_MAX) cost = COST_MAX;
      end
    end
    if (gate) cost = GATE_COST_Q16;
    r.pair_cost = cost[23:0];
    r.gated = gate;
    r.overlap = ovl[16:0];
    r.near_edge = near;
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 7);
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // valid stays up after an accept so items can follow back to back
  task automatic send_pair(pair_in_t p);
    idle_gap();
    req_valid <= 1'b1;
    req_data <= p;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    cost_queue.insert(cost_queue.size(), pair_cost_predict(p));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:    img_w_q = val[11:0];
      CFG_IMAGE_HEIGHT:   img_h_q = val[11:0];
      CFG_EDGE_FRACTION:  edge_frac_q = val;
      CFG_DISTANCE_SCALE: dist_scale_q = val;
      CFG_MISS_LIMIT:     miss_lim_q = val[7:0];
      CFG_OVERLAP_WEIGHT: ovl_wt_q = val;
      CFG_AREA_WEIGHT:    area_wt_q = val;
      CFG_CENTRE_WEIGHT:  ctr_wt_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (cost_queue.size() != 0 && !timed_out) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic pair_in_t make_pair(int d_x, int d_y, int d_w, int d_h,
                                         int t_x, int t_y, int t_w, int t_h,
                                         int miss);
    pair_in_t p;
    p.det_x = 12'(d_x); p.det_y = 12'(d_y); p.det_w = 12'(d_w); p.det_h = 12'(d_h);
    p.trk_x = 12'(t_x); p.trk_y = 12'(t_y); p.trk_w = 12'(t_w); p.trk_h = 12'(t_h);
    p.trk_misses = 8'(miss);
    return p;
  endfunction

  // mostly near-matching pairs so the cost path is reached, some raw noise
  function automatic pair_in_t random_pair(int span);
    pair_in_t p;
    int w, h;
    if ($urandom_range(0, 4) == 0) begin
      p = pair_in_t'(104'({$urandom, $urandom, $urandom, $urandom}));
    end else begin
      w = $urandom_range(1, span);
      h = $urandom_range(1, span);
      p.det_x = 12'($urandom_range(0, 4095));
      p.det_y = 12'($urandom_range(0, 4095));
      p.det_w = 12'(w);
      p.det_h = 12'(h);
      p.trk_w = 12'(w + int'($urandom_range(0, w / 3 + 1)) - (w / 6));
      p.trk_h = 12'(h + int'($urandom_range(0, h / 3 + 1)) - (h / 6));
      p.trk_x = p.det_x + 12'($urandom_range(0, w / 4 + 1)) - 12'(w / 8);
      p.trk_y = p.det_y + 12'($urandom_range(0, h / 4 + 1)) - 12'(h / 8);
      p.trk_misses = 8'($urandom);
    end
    return p;
  endfunction

  task automatic test_directed();
    send_pair(make_pair(100, 100, 50, 80, 100, 100, 50, 80, 0));
    send_pair(make_pair(0, 0, 0, 10, 0, 0, 10, 10, 3));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 255));
    send_pair(make_pair(0, 0, 4095, 4095, 0, 0, 4095, 4095, 255));
    send_pair(make_pair(500, 500, 100, 100, 520, 510, 110, 95, 5));
    send_pair(make_pair(500, 500, 100, 100, 900, 900, 100, 100, 1));
    send_pair(make_pair(500, 500, 100, 100, 500, 500, 250, 100, 0));
    send_pair(make_pair(500, 500, 100, 200, 500, 500, 200, 100, 0));
    send_pair(make_pair(10, 500, 60, 60, 5, 505, 60, 60, 10));
    send_pair(make_pair(1880, 1050, 60, 60, 1880, 1050, 60, 60, 20));
    send_pair(make_pair(1000, 500, 40, 40, 1002, 501, 41, 39, 255));
    send_pair(make_pair(3000, 3000, 1000, 900, 3000, 3000, 1000, 900, 9));
    send_pair(make_pair(200, 300, 1, 1, 200, 300, 1, 1, 128));
    drain();
  endtask

  task automatic test_register_extremes();
    int k;
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'd4095);
    write_reg(CFG_EDGE_FRACTION, 16'hFFFF);
    write_reg(CFG_DISTANCE_SCALE, 16'd0);
    write_reg(CFG_MISS_LIMIT, 16'd0);
    write_reg(CFG_OVERLAP_WEIGHT, 16'hFFFF);
    write_reg(CFG_AREA_WEIGHT, 16'hFFFF);
    write_reg(CFG_CENTRE_WEIGHT, 16'hFFFF);
    send_pair(make_pair(100, 100, 40, 40, 100, 100, 40, 40, 255));
    send_pair(make_pair(100, 100, 40, 40, 101, 100, 40, 40, 1));
    for (k = 0; k < 60; k++) send_pair(random_pair(200));
    drain();
    write_reg(CFG_IMAGE_WIDTH, 16'd4095);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    write_reg(CFG_EDGE_FRACTION, 16'd0);
    write_reg(CFG_DISTANCE_SCALE, 16'hFFFF);
    write_reg(CFG_MISS_LIMIT, 16'd255);
    write_reg(CFG_OVERLAP_WEIGHT, 16'd0);
    write_reg(CFG_AREA_WEIGHT, 16'd0);
    write_reg(CFG_CENTRE_WEIGHT, 16'd0);
    for (k = 0; k < 60; k++) send_pair(random_pair(400));
    drain();
  endtask

  task automatic test_random_settings();
    int phase, k;
    for (phase = 0; phase < 6; phase++) begin
      write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(1, 4095)));
      write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(1, 4095)));
      write_reg(CFG_EDGE_FRACTION, 16'($urandom_range(0, 16000)));
      write_reg(CFG_DISTANCE_SCALE, 16'($urandom_range(1, 1024)));
      write_reg(CFG_MISS_LIMIT, 16'($urandom_range(1, 255)));
      write_reg(CFG_OVERLAP_WEIGHT, 16'($urandom));
      write_reg(CFG_AREA_WEIGHT, 16'($urandom));
      write_reg(CFG_CENTRE_WEIGHT, 16'($urandom));
      if (phase == 5) idle_on = 1'b0;
      for (k = 0; k < 160; k++)
        send_pair(random_pair(k % 40 == 0 ? 4095 : 300));
      drain();
    end
  endtask

  initial begin
    img_w_q = RST_IMAGE_WIDTH;
    img_h_q = RST_IMAGE_HEIGHT;
    edge_frac_q = RST_EDGE_FRACTION;
    dist_scale_q = RST_DISTANCE_SCALE;
    miss_lim_q = RST_MISS_LIMIT;
    ovl_wt_q = RST_WEIGHT;
    area_wt_q = RST_WEIGHT;
    ctr_wt_q = RST_WEIGHT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_settings();
    if (mismatches == 0 && cost_queue.size() == 0 && !timed_out) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // random result stall bursts, only while idle gaps are enabled
  always @(posedge clk) begin
    if (!idle_on) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= (stall_left > 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 7);
      rsp_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pair_out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (cost_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", rsp_data);
      end else begin
        want = cost_queue.pop_front();
        if (rsp_data.pair_cost !== want.pair_cost || rsp_data.gated !== want.gated ||
            rsp_data.overlap !== want.overlap || rsp_data.near_edge !== want.near_edge) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected cost %0d gated %0b iou %0d edge %0b, got %0d %0b %0d %0b",
                     want.pair_cost, want.gated, want.overlap, want.near_edge,
                     rsp_data.pair_cost, rsp_data.gated, rsp_data.overlap,
                     rsp_data.near_edge);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item on either side while work is waiting
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cost_queue.size() == 0 && !req_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("Regression FAIL");
      $finish;
    end
  end
endmodule

/* sim.f */
rtl/btpc_pkg.sv
rtl/box_track_pair_cost.sv
tb/sv/tb_top.sv
